// ===== rtl/core/astm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// astm_pkg
// Shared types and constants of the alarm slot table matcher.
// ----------------------------------------------------------------------------
package astm_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int MINS_PER_DAY   = 24 * 60;
	localparam int MINS_PER_HOUR  = 60;
	localparam int HOUR_MAX       = 23;
	localparam int MINUTE_MAX     = 59;

	localparam logic [2:0] FUNC_ADD     = 3'd0;
	localparam logic [2:0] FUNC_REMOVE  = 3'd1;
	localparam logic [2:0] FUNC_CLR_ALL = 3'd2;
	localparam logic [2:0] FUNC_CHECK   = 3'd3;
	localparam logic [2:0] FUNC_DISMISS = 3'd4;
	localparam logic [2:0] FUNC_LIST    = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// last field in the lowest bits, as on s_axis_tdata
	typedef struct packed {
		logic [6:0] list_cap;
		logic [5:0] cur_min;
		logic [4:0] cur_hr;
		logic [5:0] slot_index;
		logic [5:0] set_min;
		logic [4:0] set_hr;
		logic [2:0] func;
	} req_t;

	typedef struct packed {
		logic        last;
		logic [10:0] minutes_until;
		logic [5:0]  out_minute;
		logic [4:0]  out_hour;
		logic [5:0]  out_slot;
		logic        has_entry;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic       triggered;
		logic       enabled;
		logic [5:0] minute;
		logic [4:0] hour;
	} slot_t;

	function automatic logic [10:0] to_mins(logic [4:0] h, logic [5:0] m);
		return 11'(h) * 11'(MINS_PER_HOUR) + 11'(m);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/alarm_slot_table_matcher_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alarm_slot_table_matcher_unit
// Alarm slot table held in one synchronous memory; commands scan it.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)
// s_axis  | in  | func, set hour, set minute, slot_index, current hour,
//         |     | current minute, list count (38 bits, padded to 40)
// m_axis  | out | status, has_entry, out_slot, out_hour, out_minute,
//         |     | minutes_until (31 bits, padded to 32); tlast = last
// One request at a time. The clear pass after reset writes every slot; not ready until it ends.
// Decode happens in a state of its own; a bad argument is answered from there.
// Each slot visit steps through an address state and an evaluate state. Remove/dismiss: one
// visit; add: up to SLOT_COUNT visits; remove-all: SLOT_COUNT; check: SLOT_COUNT plus a final state.
// List: one full scan per emitted entry (at least one scan), each closed by a final state.
// A full output register holds the scan in place until m_axis_tready.
// ----------------------------------------------------------------------------
module alarm_slot_table_matcher_unit #(
	parameter int SLOT_COUNT = astm_pkg::SLOT_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // func,ahour,amin,slot,nhour,nmin,maxc
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // status,has,slot,hour,min,until
	output logic             m_axis_tlast
);
	import astm_pkg::*;

	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);

	localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_CMD = 3'd2, S_RD = 3'd3,
		S_EV = 3'd4, S_FIN = 3'd5;

	slot_t mem [SLOT_COUNT];
	slot_t rdata_q;
	logic  we;
	slot_t wdata;

	logic [2:0]    state_q;
	req_t          req_q;
	logic [AW-1:0] idx_q;
	logic          found_q;
	logic          pass0_q;
	logic [AW-1:0] best_q;
	logic [AW-1:0] pslot_q;
	logic [10:0]   bkey_q;
	logic [10:0]   pkey_q;
	slot_t         bslot_q;
	logic [CW-1:0] cnt_q;
	logic [6:0]    nemit_q;
	rsp_t          hold_q;
	logic          hold_v_q;
	rsp_t          rsp_q;
	logic          ovalid_q;

	logic          out_free;
	logic          last_slot;
	logic          cmd_bad;
	logic          chk_hit;
	logic          lst_cand;
	logic          lst_last;
	logic          ev_go;
	logic          push_v;
	rsp_t          push_d;
	logic [10:0]   now_m;
	logic [10:0]   am;
	logic [10:0]   akey;
	logic [6:0]    lim;

	function automatic rsp_t single(logic [1:0] st, logic [5:0] sl);
		rsp_t r;
		r = '0; r.status = st; r.out_slot = sl; r.last = 1'b1;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (we) mem[idx_q] <= wdata;
		rdata_q <= mem[idx_q];
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tlast  = rsp_q.last;
	assign m_axis_tdata  = {1'b0, rsp_q.minutes_until, rsp_q.out_minute, rsp_q.out_hour,
		rsp_q.out_slot, rsp_q.has_entry, rsp_q.status};

	assign out_free  = !ovalid_q || m_axis_tready;
	assign last_slot = (32'(idx_q) == SLOT_COUNT - 1);
	assign now_m     = to_mins(req_q.cur_hr, req_q.cur_min);
	assign am        = to_mins(rdata_q.hour, rdata_q.minute);
	assign akey      = (am <= now_m) ? 11'(MINS_PER_DAY) - now_m + am : am - now_m;
	assign chk_hit   = rdata_q.enabled && !rdata_q.triggered &&
		rdata_q.hour == req_q.cur_hr && rdata_q.minute == req_q.cur_min;
	// order is (distance, slot); each pass takes the smallest after the previous pick
	assign lst_cand  = rdata_q.enabled &&
		(pass0_q || akey > pkey_q || (akey == pkey_q && idx_q > pslot_q)) &&
		(!found_q || akey < bkey_q);
	assign lim       = (req_q.list_cap < 7'(cnt_q)) ? req_q.list_cap : 7'(cnt_q);
	assign lst_last  = (8'(nemit_q) + 8'd1 >= {1'b0, lim});

	always_comb begin
		unique case (req_q.func)
			FUNC_ADD: cmd_bad = (req_q.set_hr > 5'(HOUR_MAX)) ||
				(req_q.set_min > 6'(MINUTE_MAX));
			FUNC_REMOVE, FUNC_DISMISS: cmd_bad = (32'(req_q.slot_index) >= SLOT_COUNT);
			FUNC_CLR_ALL, FUNC_CHECK: cmd_bad = 1'b0;
			FUNC_LIST: cmd_bad = (req_q.cur_hr > 5'(HOUR_MAX)) ||
				(req_q.cur_min > 6'(MINUTE_MAX));
			default: cmd_bad = 1'b1;
		endcase
	end

	always_comb begin
		we = 1'b0;
		wdata = rdata_q;
		push_v = 1'b0;
		push_d = single(ST_OK, '0);
		ev_go = 1'b1;
		unique case (state_q)
			S_CLR: begin
				we = 1'b1; wdata = '0;
			end
			S_CMD: begin
				push_v = cmd_bad && out_free;
				push_d = single(ST_INVALID, '0);
			end
			S_EV: begin
				unique case (req_q.func)
					FUNC_ADD: if (!rdata_q.enabled) begin
						ev_go = out_free; push_v = out_free; we = out_free;
						push_d = single(ST_OK, 6'(idx_q));
						wdata = '{triggered: 1'b0, enabled: 1'b1,
							minute: req_q.set_min, hour: req_q.set_hr};
					end else if (last_slot) begin
						ev_go = out_free; push_v = out_free;
						push_d = single(ST_FULL, '0);
					end
					FUNC_REMOVE: begin
						ev_go = out_free; push_v = out_free; we = out_free;
						wdata.enabled = 1'b0; wdata.triggered = 1'b0;
					end
					FUNC_DISMISS: begin
						ev_go = out_free; push_v = out_free; we = out_free;
						wdata.triggered = 1'b0;
					end
					FUNC_CLR_ALL: begin
						we = 1'b1; wdata.enabled = 1'b0; wdata.triggered = 1'b0;
						if (last_slot) begin
							ev_go = out_free; push_v = out_free;
						end
					end
					FUNC_CHECK: if (chk_hit) begin
						// a held hit goes out once the next one is known
						ev_go = !hold_v_q || out_free;
						we = ev_go; wdata.triggered = 1'b1;
						push_v = hold_v_q && out_free;
						push_d = hold_q;
					end
					default: ;
				endcase
			end
			S_FIN: begin
				push_v = out_free;
				if (req_q.func == FUNC_CHECK && hold_v_q) begin
					push_d = hold_q; push_d.last = 1'b1;
				end else if (req_q.func == FUNC_LIST && found_q && lim != '0) begin
					push_d = '{last: lst_last, minutes_until: bkey_q,
						out_minute: bslot_q.minute, out_hour: bslot_q.hour,
						out_slot: 6'(best_q), has_entry: 1'b1, status: ST_OK};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; req_q <= '0; idx_q <= '0; found_q <= 1'b0;
			pass0_q <= 1'b0; best_q <= '0; pslot_q <= '0; bkey_q <= '0;
			pkey_q <= '0; bslot_q <= '0; cnt_q <= '0; nemit_q <= '0;
			hold_q <= '0; hold_v_q <= 1'b0; rsp_q <= '0; ovalid_q <= 1'b0;
		end else begin
			if (push_v) begin
				rsp_q <= push_d; ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: if (last_slot) begin
					idx_q <= '0; state_q <= S_IDLE;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
				S_IDLE: if (s_axis_tvalid) begin
					req_q <= s_axis_tdata[37:0];
					state_q <= S_CMD;
				end
				S_CMD: if (cmd_bad) begin
					if (out_free) state_q <= S_IDLE;
				end else begin
					idx_q <= (req_q.func == FUNC_REMOVE || req_q.func == FUNC_DISMISS) ?
						AW'(req_q.slot_index) : '0;
					found_q <= 1'b0; pass0_q <= 1'b1; hold_v_q <= 1'b0;
					nemit_q <= '0; cnt_q <= '0;
					state_q <= S_RD;
				end
				S_RD: state_q <= S_EV;
				S_EV: if (ev_go) begin
					unique case (req_q.func)
						FUNC_ADD: if (!rdata_q.enabled || last_slot) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1; state_q <= S_RD;
						end
						FUNC_CLR_ALL: if (last_slot) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1; state_q <= S_RD;
						end
						FUNC_CHECK: begin
							if (chk_hit) begin
								hold_q <= '{last: 1'b0, minutes_until: '0,
									out_minute: rdata_q.minute, out_hour: rdata_q.hour,
									out_slot: 6'(idx_q), has_entry: 1'b1, status: ST_OK};
								hold_v_q <= 1'b1;
							end
							if (last_slot) begin
								state_q <= S_FIN;
							end else begin
								idx_q <= idx_q + 1'b1; state_q <= S_RD;
							end
						end
						FUNC_LIST: begin
							if (lst_cand) begin
								found_q <= 1'b1; best_q <= idx_q; bkey_q <= akey;
								bslot_q <= rdata_q;
							end
							if (pass0_q && rdata_q.enabled) cnt_q <= CW'(cnt_q + 1'b1);
							if (last_slot) begin
								state_q <= S_FIN;
							end else begin
								idx_q <= idx_q + 1'b1; state_q <= S_RD;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_FIN: if (out_free) begin
					if (req_q.func == FUNC_LIST && found_q && lim != '0 && !lst_last) begin
						nemit_q <= 7'(nemit_q + 1'b1);
						pkey_q <= bkey_q; pslot_q <= best_q;
						found_q <= 1'b0; pass0_q <= 1'b0; idx_q <= '0;
						state_q <= S_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== bench/alarm_slot_table_matcher_unit_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alarm_slot_table_matcher_unit_tb
// Directed table then weighted random requests; every response is checked
// field by field against an in-bench model of the alarm slot table.
// ----------------------------------------------------------------------------
module alarm_slot_table_matcher_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import astm_pkg::*;

	localparam int NSLOT = SLOT_COUNT_DEF;
	localparam int RAND_ITEMS = 440;

	typedef struct {
		logic [2:0]  func;
		logic [4:0]  ahour;
		logic [5:0]  amin;
		logic [5:0]  idx;
		logic [4:0]  nhour;
		logic [5:0]  nmin;
		logic [6:0]  maxc;
		bit          typed;
		logic [1:0]  tstatus;
		logic [5:0]  tslot;
	} alarm_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        has;
		logic [5:0]  slot;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [10:0] wait_min;
		logic        last;
	} alarm_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	alarm_slot_table_matcher_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	logic [4:0] tbl_hour [NSLOT];
	logic [5:0] tbl_min  [NSLOT];
	bit         tbl_en   [NSLOT];
	bit         tbl_trig [NSLOT];

	alarm_rsp_t pending_rsp[$];
	int         err_cnt = 0;
	bit         quiet_sink = 0;

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	initial begin
		#20ms;
		$display("alarm_slot_table_matcher_unit verification failed");
		$finish;
	end

	function automatic alarm_rsp_t status_rsp(logic [1:0] st, logic [5:0] slot);
		alarm_rsp_t r;
		r = '{status: st, has: 1'b0, slot: slot, hour: '0, minute: '0,
			wait_min: '0, last: 1'b1};
		return r;
	endfunction

	function automatic alarm_rsp_t entry_rsp(int s, logic [10:0] wm);
		alarm_rsp_t r;
		r = '{status: ST_OK, has: 1'b1, slot: 6'(s), hour: tbl_hour[s],
			minute: tbl_min[s], wait_min: wm, last: 1'b0};
		return r;
	endfunction

	// update the table and queue the responses one request causes
	task automatic apply_alarm_cmd(input alarm_req_t q);
		alarm_rsp_t  out[$];
		int          now_m, a, best, lim;
		int          delta [NSLOT];
		bit          taken [NSLOT];
		bit          done;
		done = 0;
		case (q.func)
			FUNC_ADD: begin
				if (q.ahour > HOUR_MAX || q.amin > MINUTE_MAX)
					out.push_back(status_rsp(ST_INVALID, 0));
				else begin
					for (int i = 0; i < NSLOT && !done; i++)
						if (!tbl_en[i]) begin
							tbl_hour[i] = q.ahour; tbl_min[i] = q.amin;
							tbl_en[i] = 1; tbl_trig[i] = 0; done = 1;
							out.push_back(status_rsp(ST_OK, 6'(i)));
						end
					if (!done) out.push_back(status_rsp(ST_FULL, 0));
				end
			end
			FUNC_REMOVE, FUNC_DISMISS: begin
				if (q.idx >= NSLOT)
					out.push_back(status_rsp(ST_INVALID, 0));
				else begin
					if (q.func == FUNC_REMOVE) tbl_en[q.idx] = 0;
					tbl_trig[q.idx] = 0;
					out.push_back(status_rsp(ST_OK, 0));
				end
			end
			FUNC_CLR_ALL: begin
				for (int i = 0; i < NSLOT; i++) begin
					tbl_en[i] = 0; tbl_trig[i] = 0;
				end
				out.push_back(status_rsp(ST_OK, 0));
			end
			FUNC_CHECK: begin
				for (int i = 0; i < NSLOT; i++)
					if (tbl_en[i] && !tbl_trig[i] && tbl_hour[i] == q.nhour
							&& tbl_min[i] == q.nmin) begin
						tbl_trig[i] = 1;
						out.push_back(entry_rsp(i, 0));
					end
				if (out.size() == 0) out.push_back(status_rsp(ST_OK, 0));
			end
			FUNC_LIST: begin
				if (q.nhour > HOUR_MAX || q.nmin > MINUTE_MAX)
					out.push_back(status_rsp(ST_INVALID, 0));
				else begin
					now_m = q.nhour * MINS_PER_HOUR + q.nmin;
					for (int i = 0; i < NSLOT; i++) begin
						a = tbl_hour[i] * MINS_PER_HOUR + tbl_min[i];
						if (a <= now_m) a += MINS_PER_DAY;
						delta[i] = a - now_m;
						taken[i] = !tbl_en[i];
					end
					lim = (q.maxc < NSLOT) ? q.maxc : NSLOT;
					while (out.size() < lim && !done) begin
						best = -1;
						for (int i = 0; i < NSLOT; i++)
							if (!taken[i] && (best < 0 || delta[i] < delta[best]))
								best = i;
						if (best < 0) done = 1;
						else begin
							taken[best] = 1;
							out.push_back(entry_rsp(best, 11'(delta[best])));
						end
					end
					if (out.size() == 0) out.push_back(status_rsp(ST_OK, 0));
				end
			end
			default: out.push_back(status_rsp(ST_INVALID, 0));
		endcase
		out[out.size() - 1].last = 1'b1;
		if (q.typed) out[0] = status_rsp(q.tstatus, q.tslot);
		foreach (out[i]) pending_rsp.push_back(out[i]);
	endtask

	function automatic alarm_req_t mk_req(logic [2:0] f, logic [4:0] ah,
			logic [5:0] am, logic [5:0] ix, logic [4:0] nh, logic [5:0] nm,
			logic [6:0] mc);
		alarm_req_t q;
		q = '{func: f, ahour: ah, amin: am, idx: ix, nhour: nh, nmin: nm,
			maxc: mc, typed: 0, tstatus: ST_OK, tslot: 0};
		return q;
	endfunction

	function automatic alarm_req_t typed_req(alarm_req_t q, logic [1:0] st,
			logic [5:0] slot);
		q.typed = 1; q.tstatus = st; q.tslot = slot;
		return q;
	endfunction

	// small time pool so that check and list hit stored alarms often
	function automatic void pool_time(output logic [4:0] h, output logic [5:0] m);
		case ($urandom_range(0, 5))
			0: begin h = 0;  m = 0;  end
			1: begin h = 23; m = 59; end
			2: begin h = 7;  m = 30; end
			3: begin h = 16; m = 33; end
			4: begin h = 12; m = 15; end
			default: begin
				h = 5'($urandom_range(0, 23)); m = 6'($urandom_range(0, 59));
			end
		endcase
	endfunction

	function automatic alarm_req_t rand_req();
		alarm_req_t  q;
		logic [4:0]  h, nh;
		logic [5:0]  m, nm;
		int          w;
		pool_time(h, m);
		pool_time(nh, nm);
		q = mk_req(3'($urandom_range(0, 7)), 5'($urandom), 6'($urandom),
			6'($urandom), 5'($urandom), 6'($urandom), 7'($urandom_range(0, 64)));
		w = $urandom_range(0, 99);
		if (w < 30) begin
			q.func = FUNC_ADD;
			if ($urandom_range(0, 9) != 0) begin q.ahour = h; q.amin = m; end
		end else if (w < 50) begin
			q.func = FUNC_CHECK;
			if ($urandom_range(0, 9) != 0) begin q.nhour = nh; q.nmin = nm; end
		end else if (w < 68) begin
			q.func = FUNC_LIST;
			if ($urandom_range(0, 9) != 0) begin q.nhour = nh; q.nmin = nm; end
		end else if (w < 80) begin
			q.func = FUNC_REMOVE;
			if ($urandom_range(0, 4) != 0) q.idx = 6'($urandom_range(0, NSLOT - 1));
		end else if (w < 92) begin
			q.func = FUNC_DISMISS;
			if ($urandom_range(0, 4) != 0) q.idx = 6'($urandom_range(0, NSLOT - 1));
		end else if (w < 96)
			q.func = FUNC_CLR_ALL;
		return q;
	endfunction

	task automatic send_req(input alarm_req_t q, input bit idle_on);
		int gap;
		gap = idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, q.maxc, q.nmin, q.nhour, q.idx, q.amin,
			q.ahour, q.func};
		do @(posedge clk); while (!s_axis_tready);
		apply_alarm_cmd(q);
	endtask

	alarm_req_t dir_tab[$];

	initial begin
		bit idle_on;
		int waited;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		for (int i = 0; i < NSLOT; i++) begin
			tbl_hour[i] = 0; tbl_min[i] = 0; tbl_en[i] = 0; tbl_trig[i] = 0;
		end
		dir_tab = '{
			typed_req(mk_req(FUNC_LIST, 0, 0, 0, 0, 0, 64), ST_OK, 0),
			typed_req(mk_req(FUNC_CHECK, 0, 0, 0, 0, 0, 0), ST_OK, 0),
			typed_req(mk_req(FUNC_ADD, 0, 0, 0, 0, 0, 0), ST_OK, 0),
			typed_req(mk_req(FUNC_ADD, 23, 59, 0, 0, 0, 0), ST_OK, 1),
			typed_req(mk_req(FUNC_ADD, 24, 0, 0, 0, 0, 0), ST_INVALID, 0),
			typed_req(mk_req(FUNC_ADD, 0, 60, 0, 0, 0, 0), ST_INVALID, 0),
			typed_req(mk_req(FUNC_ADD, 31, 63, 63, 31, 63, 127), ST_INVALID, 0),
			mk_req(FUNC_ADD, 7, 30, 0, 0, 0, 0),
			mk_req(FUNC_ADD, 23, 59, 0, 0, 0, 0),
			mk_req(FUNC_ADD, 16, 33, 0, 0, 0, 0),
			mk_req(FUNC_ADD, 12, 15, 0, 0, 0, 0),
			mk_req(FUNC_ADD, 0, 1, 0, 0, 0, 0),
			mk_req(FUNC_ADD, 23, 58, 0, 0, 0, 0),
			typed_req(mk_req(FUNC_ADD, 5, 5, 0, 0, 0, 0), ST_FULL, 0),
			mk_req(FUNC_CHECK, 0, 0, 0, 23, 59, 0),
			mk_req(FUNC_CHECK, 0, 0, 0, 23, 59, 0),
			mk_req(FUNC_CHECK, 0, 0, 0, 31, 63, 0),
			typed_req(mk_req(FUNC_DISMISS, 0, 0, 1, 0, 0, 0), ST_OK, 0),
			typed_req(mk_req(FUNC_REMOVE, 0, 0, 63, 0, 0, 0), ST_INVALID, 0),
			typed_req(mk_req(FUNC_DISMISS, 0, 0, 8, 0, 0, 0), ST_INVALID, 0),
			mk_req(FUNC_LIST, 0, 0, 0, 0, 0, 64),
			mk_req(FUNC_LIST, 0, 0, 0, 23, 59, 3),
			typed_req(mk_req(FUNC_LIST, 0, 0, 0, 0, 0, 0), ST_OK, 0),
			typed_req(mk_req(FUNC_LIST, 0, 0, 0, 24, 0, 8), ST_INVALID, 0),
			typed_req(mk_req(FUNC_LIST, 0, 0, 0, 0, 63, 8), ST_INVALID, 0),
			typed_req(mk_req(3'd6, 0, 0, 0, 0, 0, 0), ST_INVALID, 0),
			typed_req(mk_req(3'd7, 0, 0, 0, 0, 0, 0), ST_INVALID, 0),
			typed_req(mk_req(FUNC_REMOVE, 0, 0, 0, 0, 0, 0), ST_OK, 0),
			typed_req(mk_req(FUNC_CLR_ALL, 0, 0, 0, 0, 0, 0), ST_OK, 0)
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) send_req(dir_tab[i], 1'b1);
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
			send_req(rand_req(), idle_on);
		end
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (pending_rsp.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);
		if (err_cnt == 0 && pending_rsp.size() == 0)
			$display("alarm_slot_table_matcher_unit verification clean");
		else
			$display("alarm_slot_table_matcher_unit verification failed");
		$finish;
	end

	// response sink with random backpressure
	initial begin
		alarm_rsp_t e;
		alarm_rsp_t got;
		int         stall;
		int         n;
		m_axis_tready = 1'b0;
		n = 0;
		forever begin
			if (n % 40 == 0) quiet_sink = ($urandom_range(0, 3) == 0);
			stall = quiet_sink ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && arst_n));
			n++;
			got = '{status: m_axis_tdata[1:0], has: m_axis_tdata[2],
				slot: m_axis_tdata[8:3], hour: m_axis_tdata[13:9],
				minute: m_axis_tdata[19:14], wait_min: m_axis_tdata[30:20],
				last: m_axis_tlast};
			if (pending_rsp.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected response %p", got);
			end else begin
				e = pending_rsp.pop_front();
				if (got !== e) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: expected %p actual %p", e, got);
				end
			end
		end
	end

endmodule
`default_nettype wire
